// ----- rtl/scd_pkg.sv -----
// Shared types and constants for the logic-analyzer command decoder.
// Used by the front, queue and back modules and by the top level; no dependencies.
package scd_pkg;

  // Result kinds, as they appear on the output kind field.
  typedef enum logic [3:0] {
    EV_REPLY  = 4'd1,
    EV_ARM    = 4'd2,
    EV_RESET  = 4'd3,
    EV_MASK   = 4'd4,
    EV_VALUE  = 4'd5,
    EV_TRIG   = 4'd6,
    EV_DIV    = 4'd7,
    EV_COUNTS = 4'd8,
    EV_FLAGS  = 4'd9
  } event_t;

  // One classified command as it waits in the queue.
  typedef struct packed {
    event_t     ev;
    logic [1:0] stage;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } entry_t;

  // One result item before it is packed onto the output bus.
  typedef struct packed {
    event_t      ev;
    logic [1:0]  stage;
    logic [7:0]  reply_byte;
    logic        last;
    logic [31:0] word;
    logic [16:0] first_count;
    logic [16:0] second_count;
    logic [1:0]  level;
    logic [4:0]  channel;
    logic        serial_flag;
    logic        start_flag;
    logic [7:0]  flag_bits;
  } result_t;

  // Identification string sent in reply to an ID request, first byte first.
  function automatic logic [7:0] id_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h31;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h4C;
      default: b = 8'h53;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/scd_front.sv -----
// Front end of the command decoder: takes received bytes, tracks the frame
// position, collects frame bytes and classifies commands. Depends on scd_pkg.
module scd_front import scd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] rx_byte,
  output logic       in_ready,
  input  logic       queue_full,
  output logic       push,
  output entry_t     push_entry
);

  localparam logic [7:0] CMD_RESET  = 8'h00;
  localparam logic [7:0] CMD_ARM    = 8'h01;
  localparam logic [7:0] CMD_ID     = 8'h02;
  localparam logic [7:0] CMD_ID_ALT = 8'h31;
  localparam logic [7:0] CMD_META   = 8'h04;
  localparam logic [7:0] CMD_XON    = 8'h11;
  localparam logic [7:0] CMD_XOFF   = 8'h13;

  localparam logic [7:0] OP_KEEP    = 8'hF3;
  localparam logic [7:0] OP_MASK    = 8'hC0;
  localparam logic [7:0] OP_VALUE   = 8'hC1;
  localparam logic [7:0] OP_TRIG    = 8'hC2;
  localparam logic [7:0] OP_DIV     = 8'h80;
  localparam logic [7:0] OP_COUNTS  = 8'h81;
  localparam logic [7:0] OP_FLAGS   = 8'h82;

  logic [2:0] pos;
  logic [2:0] pos_next;
  logic [7:0] b0, b1, b2, b3;
  logic       accept;
  logic [7:0] opcode;
  logic       single;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign opcode   = b0 & OP_KEEP;

  always_comb begin
    pos_next         = pos;
    push             = 1'b0;
    single           = 1'b0;
    push_entry.ev    = EV_RESET;
    push_entry.stage = 2'd0;
    push_entry.b1    = b1;
    push_entry.b2    = b2;
    push_entry.b3    = b3;
    push_entry.b4    = rx_byte;
    if (accept && pos == 3'd0) begin
      single = 1'b1;
      unique case (rx_byte) inside
        CMD_RESET: begin
          push          = 1'b1;
          push_entry.ev = EV_RESET;
        end
        CMD_ARM: begin
          push          = 1'b1;
          push_entry.ev = EV_ARM;
        end
        CMD_ID, CMD_ID_ALT: begin
          push          = 1'b1;
          push_entry.ev = EV_REPLY;
        end
        CMD_META, CMD_XON, CMD_XOFF: begin
          push = 1'b0;
        end
        default: begin
          single   = 1'b0;
          pos_next = 3'd1;
        end
      endcase
    end else if (accept && pos != 3'd4) begin
      pos_next = pos + 3'd1;
    end else if (accept) begin
      // Fifth byte: the frame is complete and is decoded now.
      pos_next = 3'd0;
      push     = 1'b1;
      unique case (opcode)
        OP_MASK: begin
          push_entry.ev    = EV_MASK;
          push_entry.stage = b0[3:2];
        end
        OP_VALUE: begin
          push_entry.ev    = EV_VALUE;
          push_entry.stage = b0[3:2];
        end
        OP_TRIG: begin
          push_entry.ev    = EV_TRIG;
          push_entry.stage = b0[3:2];
        end
        OP_DIV:    push_entry.ev = EV_DIV;
        OP_COUNTS: push_entry.ev = EV_COUNTS;
        OP_FLAGS:  push_entry.ev = EV_FLAGS;
        default:   push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else begin
      pos <= pos_next;
    end
  end

  // Frame bytes carry no reset; each is written before the frame is decoded.
  always_ff @(posedge clk) begin
    if (accept && !single) begin
      case (pos)
        3'd0:    b0 <= rx_byte;
        3'd1:    b1 <= rx_byte;
        3'd2:    b2 <= rx_byte;
        3'd3:    b3 <= rx_byte;
        default: ;
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= 3'd4)
    else $error("frame position out of range");

endmodule

// ----- rtl/scd_queue.sv -----
// Short command queue between the front and the back end of the decoder.
// Depends on scd_pkg for the entry type.
module scd_queue import scd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output logic   valid,
  input  logic   pop,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rptr];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wrap_inc(wptr);
      end
      if (pop) begin
        rptr <= wrap_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("command queue read while empty");

endmodule

// ----- rtl/scd_back.sv -----
// Back end of the decoder: expands queued commands into result items and
// holds them in the output register. Depends on scd_pkg.
module scd_back import scd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  entry_t  head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic [1:0] idx;
  logic       load;
  logic       is_reply;
  result_t    item;

  assign is_reply = (head.ev == EV_REPLY);
  assign load     = head_valid && (!out_valid || out_ready);
  assign pop      = load && (!is_reply || idx == 2'd3);

  always_comb begin
    item      = '0;
    item.ev   = head.ev;
    item.last = !is_reply || idx == 2'd3;
    unique case (head.ev) inside
      EV_REPLY: item.reply_byte = id_byte(idx);
      EV_MASK, EV_VALUE: begin
        item.stage = head.stage;
        item.word  = {head.b4, head.b3, head.b2, head.b1};
      end
      EV_TRIG: begin
        item.stage       = head.stage;
        item.first_count = {1'b0, head.b2, head.b1};
        item.level       = head.b3[1:0];
        item.channel     = {head.b4[0], head.b3[7:4]};
        item.serial_flag = head.b4[2];
        item.start_flag  = head.b4[3];
      end
      EV_DIV: item.word = {8'd0, head.b3, head.b2, head.b1} + 32'd1;
      EV_COUNTS: begin
        item.first_count  = {1'b0, head.b2, head.b1} + 17'd1;
        item.second_count = {1'b0, head.b4, head.b3} + 17'd1;
      end
      EV_FLAGS: item.flag_bits = head.b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && is_reply) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item;
    end
  end

  a_idx_reply: assert property (@(posedge clk) disable iff (rst)
      idx != 2'd0 |-> head_valid && is_reply)
    else $error("reply index moved without an ID command at the head");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
      pop |=> out_valid && out_item.last)
    else $error("command retired without its final item");

endmodule

// ----- rtl/sump_command_decoder_top.sv -----
// Top level of the logic-analyzer command decoder: stream ports, packing.
// Instantiates scd_front, scd_queue and scd_back; depends on scd_pkg.
//
// The decoder takes one received command byte per item on the slave side and
// accepts a new byte in every clock cycle while its command queue has room.
// A byte that completes a command (reset, arm, ID request or the fifth byte of
// a recognized five-byte frame) places one entry in a short queue; the back end
// turns each entry into result items on the master side at one item per cycle
// while the master side is ready. Reset, arm and frame commands give one item;
// an ID request gives four reply items, the ASCII bytes of "1ALS", the last
// marked by tlast. Metadata, XON, XOFF, the first four frame bytes and frames
// with an unknown opcode give no item. A completed command goes through the
// queue, then the single output register, which holds one item at a time, so
// an ID request holds the output for four items and all other commands for one.
// The queue depth (QUEUE_DEPTH) is how many completed commands may wait while
// the master side stalls before the slave side stops accepting bytes.
module sump_command_decoder_top import scd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] stage, [9:2] reply_byte, [41:10] word, [58:42] first_count,
  // [75:59] second_count, [77:76] level, [82:78] channel, [83] serial_flag,
  // [84] start_flag, [92:85] flag_bits, [95:93] zero
  output logic [95:0] m_tdata,
  output logic [3:0]  m_tuser,   // [3:0] event_res
  output logic        m_tlast    // last item caused by one input byte
);

  logic    queue_full;
  logic    push;
  entry_t  push_entry;
  logic    head_valid;
  entry_t  head;
  logic    pop;
  result_t out_item;

  scd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .rx_byte    (s_tdata),
    .in_ready   (s_tready),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  scd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .valid      (head_valid),
    .pop        (pop),
    .head       (head)
  );

  scd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_item   (out_item)
  );

  // The kind of each item travels in tuser; the remaining fields are packed
  // into tdata from the lowest bit up and padded to whole bytes.
  assign m_tuser = out_item.ev;
  assign m_tlast = out_item.last;
  assign m_tdata = {3'd0,
                    out_item.flag_bits,
                    out_item.start_flag,
                    out_item.serial_flag,
                    out_item.channel,
                    out_item.level,
                    out_item.second_count,
                    out_item.first_count,
                    out_item.word,
                    out_item.reply_byte,
                    out_item.stage};

endmodule
